>>> hw/rtl/svc_pkg.sv
// ----------------------------------------------------------------------------
// svc_pkg
// Shared types and constants for the superpixel majority-vote compositor.
// ----------------------------------------------------------------------------
package svc_pkg;

    localparam int LABELS     = 4096;
    localparam int IMAGES     = 8;
    localparam int COUNT_W    = 22;
    localparam int LABEL_W    = $clog2(LABELS);
    localparam int IMG_W      = $clog2(IMAGES);
    localparam int CNT_ADDR_W = LABEL_W + IMG_W;
    localparam int CHAN_W     = 8;
    localparam int ICNT_W     = 4;
    localparam int PASS_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // request codes
    localparam logic [1:0] REQ_VOTE    = 2'd0;
    localparam logic [1:0] REQ_RESOLVE = 2'd1;
    localparam logic [1:0] REQ_APPLY   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_IMAGE  = 1'b1;

    localparam logic [ICNT_W-1:0] IMAGE_COUNT_RESET = ICNT_W'(IMAGES);
    localparam logic [ICNT_W-1:0] IMAGE_COUNT_MAX   = ICNT_W'(IMAGES);
    localparam logic [IMG_W-1:0]  LAST_IMAGE        = IMG_W'(IMAGES - 1);

    typedef struct packed {
        logic [1:0]        req_type;
        logic [LABEL_W-1:0] label;
        logic [IMG_W-1:0]  vote_image;
        logic [CHAN_W-1:0] src_chan0;
        logic [CHAN_W-1:0] src_chan1;
        logic [CHAN_W-1:0] src_chan2;
    } t_in_item;

    typedef struct packed {
        logic              take_pixel;
        logic [CHAN_W-1:0] out_chan0;
        logic [CHAN_W-1:0] out_chan1;
        logic [CHAN_W-1:0] out_chan2;
    } t_out_item;

    // winner table write from the resolve walk
    typedef struct packed {
        logic               en;
        logic [LABEL_W-1:0] label;
        logic [IMG_W-1:0]   image;
    } t_winner_wr;

endpackage

>>> hw/rtl/svc_winner_unit.sv
// ----------------------------------------------------------------------------
// svc_winner_unit
// Winner table memory: written by the resolve walk, read by apply items.
// ----------------------------------------------------------------------------
module svc_winner_unit (
    input  logic                         i_clk,
    input  svc_pkg::t_winner_wr          i_winner_wr,
    input  logic                         i_rd_en,
    input  logic [svc_pkg::LABEL_W-1:0]  i_rd_label,
    output logic [svc_pkg::IMG_W-1:0]    o_winner
);

    logic [svc_pkg::IMG_W-1:0] mem [svc_pkg::LABELS];
    logic [svc_pkg::IMG_W-1:0] r_rd;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_winner_wr.en) begin
            mem[i_winner_wr.label] <= i_winner_wr.image;
        end
        if (i_rd_en) begin
            r_rd <= mem[i_rd_label];
        end
    end

    assign o_winner = r_rd;

endmodule

>>> hw/rtl/svc_vote_unit.sv
// ----------------------------------------------------------------------------
// svc_vote_unit
// Vote count memory with saturating read-modify-write, and the walk that
// clears it after reset and, clearing it again, resolves per-label winners on request.
// ----------------------------------------------------------------------------
module svc_vote_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vote_en,
    input  logic [svc_pkg::CNT_ADDR_W-1:0]  i_vote_addr,
    input  logic                            i_resolve,
    input  logic [svc_pkg::ICNT_W-1:0]      i_active_images,
    output logic                            o_busy,
    output svc_pkg::t_winner_wr             o_winner_wr
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_walk_state;

    t_walk_state r_state;

    logic [svc_pkg::COUNT_W-1:0]    mem [2**svc_pkg::CNT_ADDR_W];
    logic [svc_pkg::COUNT_W-1:0]    r_rd;

    logic [svc_pkg::CNT_ADDR_W-1:0] r_walk_addr;
    logic                           r_cmp_valid;
    logic [svc_pkg::CNT_ADDR_W-1:0] r_cmp_addr;
    logic [svc_pkg::COUNT_W-1:0]    r_best;
    logic [svc_pkg::IMG_W-1:0]      r_win;

    logic                           r_s1_valid;
    logic [svc_pkg::CNT_ADDR_W-1:0] r_s1_addr;
    logic                           r_fwd_valid;
    logic [svc_pkg::CNT_ADDR_W-1:0] r_fwd_addr;
    logic [svc_pkg::COUNT_W-1:0]    r_fwd_data;

    logic                           walking;
    logic                           mem_re;
    logic [svc_pkg::CNT_ADDR_W-1:0] mem_ra;
    logic                           mem_we;
    logic [svc_pkg::CNT_ADDR_W-1:0] mem_wa;
    logic [svc_pkg::COUNT_W-1:0]    mem_wd;
    logic [svc_pkg::COUNT_W-1:0]    cur_count;
    logic [svc_pkg::COUNT_W-1:0]    inc_count;

    logic [svc_pkg::IMG_W-1:0]      cmp_img;
    logic [svc_pkg::COUNT_W-1:0]    best_in;
    logic [svc_pkg::IMG_W-1:0]      win_in;
    logic                           beats;
    logic [svc_pkg::COUNT_W-1:0]    n_best;
    logic [svc_pkg::IMG_W-1:0]      n_win;

    assign walking = (r_state == ST_CLEAR) || (r_state == ST_WALK);

    // vote increment, forwarding the write of the previous vote
    always_comb begin
        cur_count = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_rd;
        inc_count = (cur_count == '1) ? cur_count : cur_count + 1'b1;
    end

    // memory port selection: the walk and votes never overlap
    always_comb begin
        mem_re = i_vote_en || (r_state == ST_WALK);
        mem_ra = (r_state == ST_WALK) ? r_walk_addr : i_vote_addr;
        mem_we = walking || r_s1_valid;
        mem_wa = walking ? r_walk_addr : r_s1_addr;
        mem_wd = walking ? '0 : inc_count;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    // winner scan, strict greater-than so ties keep the lower image
    always_comb begin
        cmp_img = r_cmp_addr[svc_pkg::IMG_W-1:0];
        best_in = (cmp_img == '0) ? '0 : r_best;
        win_in  = (cmp_img == '0) ? '0 : r_win;
        beats   = ({1'b0, cmp_img} < i_active_images) && (r_rd > best_in);
        n_best  = beats ? r_rd : best_in;
        n_win   = beats ? cmp_img : win_in;
    end

    assign o_winner_wr.en    = r_cmp_valid && (cmp_img == svc_pkg::LAST_IMAGE);
    assign o_winner_wr.label = r_cmp_addr[svc_pkg::CNT_ADDR_W-1:svc_pkg::IMG_W];
    assign o_winner_wr.image = n_win;

    assign o_busy = (r_state != ST_IDLE) || r_cmp_valid;

    // walk sequencer, vote stage and forwarding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_walk_addr <= '0;
            r_cmp_valid <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_cmp_valid <= (r_state == ST_WALK);
            r_cmp_addr  <= r_walk_addr;
            if (r_cmp_valid) begin
                r_best <= n_best;
                r_win  <= n_win;
            end
            r_s1_valid <= i_vote_en;
            r_s1_addr  <= i_vote_addr;
            if (r_s1_valid) begin
                r_fwd_valid <= 1'b1;
                r_fwd_addr  <= r_s1_addr;
                r_fwd_data  <= inc_count;
            end
            unique case (r_state)
                ST_CLEAR, ST_WALK: begin
                    r_fwd_valid <= 1'b0;
                    r_walk_addr <= r_walk_addr + 1'b1;
                    if (r_walk_addr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    r_walk_addr <= '0;
                    if (i_resolve) begin
                        r_state <= ST_WALK;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/superpixel_majority_vote_compositor_top.sv
// ----------------------------------------------------------------------------
// superpixel_majority_vote_compositor_top
// Per-label majority vote over source images, winner resolve and pixel apply.
// ----------------------------------------------------------------------------
// Vote and apply items are taken one per cycle while the output is not
// stalled. A resolve item walks the whole vote count memory, one count per
// cycle through its single read and write port, clearing each count, so the
// block takes no item until the walk and its last compare are done. After
// reset the same walk clears the count memory: no item is taken until it is
// done, while configuration writes are taken at any time. An apply item
// gives its result through the winner table read and the output register.
module superpixel_majority_vote_compositor_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  svc_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output svc_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_we,
    input  logic [svc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [svc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [svc_pkg::ICNT_W-1:0] r_image_count;
    logic [svc_pkg::PASS_W-1:0] r_pass_image;
    logic [svc_pkg::ICNT_W-1:0] active_images;

    logic                       r_ap_valid;
    svc_pkg::t_in_item          r_ap_item;
    logic                       r_out_valid;
    svc_pkg::t_out_item         r_out_item;

    logic                       busy;
    logic                       accept;
    logic                       ap_adv;
    logic                       vote_en;
    logic                       resolve;
    logic                       apply;
    svc_pkg::t_winner_wr        winner_wr;
    logic [svc_pkg::IMG_W-1:0]  winner;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_count <= svc_pkg::IMAGE_COUNT_RESET;
            r_pass_image  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                svc_pkg::CFG_IMAGE_COUNT: r_image_count <= i_cfg_data;
                svc_pkg::CFG_PASS_IMAGE:  r_pass_image  <= i_cfg_data[svc_pkg::PASS_W-1:0];
                default: ;
            endcase
        end
    end

    assign active_images = (r_image_count > svc_pkg::IMAGE_COUNT_MAX) ?
                           svc_pkg::IMAGE_COUNT_MAX : r_image_count;

    // input handshake and request decode
    assign ap_adv     = r_ap_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !busy && (!r_ap_valid || ap_adv);
    assign accept     = i_in_valid && o_in_ready;
    assign vote_en    = accept && (i_in_item.req_type == svc_pkg::REQ_VOTE) &&
                        ({1'b0, i_in_item.vote_image} < active_images);
    assign resolve    = accept && (i_in_item.req_type == svc_pkg::REQ_RESOLVE);
    assign apply      = accept && (i_in_item.req_type == svc_pkg::REQ_APPLY);

    svc_vote_unit u_vote (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vote_en       (vote_en),
        .i_vote_addr     ({i_in_item.label, i_in_item.vote_image}),
        .i_resolve       (resolve),
        .i_active_images (active_images),
        .o_busy          (busy),
        .o_winner_wr     (winner_wr)
    );

    svc_winner_unit u_winner (
        .i_clk       (i_clk),
        .i_winner_wr (winner_wr),
        .i_rd_en     (apply),
        .i_rd_label  (i_in_item.label),
        .o_winner    (winner)
    );

    // apply stage waits on the winner read, then moves to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ap_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (apply) begin
                r_ap_valid <= 1'b1;
                r_ap_item  <= i_in_item;
            end else if (ap_adv) begin
                r_ap_valid <= 1'b0;
            end
            if (ap_adv) begin
                r_out_valid          <= 1'b1;
                r_out_item.take_pixel <= (winner == r_pass_image);
                r_out_item.out_chan0 <= r_ap_item.src_chan0;
                r_out_item.out_chan1 <= r_ap_item.src_chan1;
                r_out_item.out_chan2 <= r_ap_item.src_chan2;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> tb/superpixel_majority_vote_compositor_top_test.sv
// ----------------------------------------------------------------------------
// superpixel_majority_vote_compositor_top_test
// Self-checking bench for the superpixel majority-vote compositor.
// Phases of vote, resolve and apply items run under several image counts and
// pass images. A tally of votes per label and image predicts the winner table
// and every apply result, which is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module superpixel_majority_vote_compositor_top_test;
    import svc_pkg::*;

    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam int unsigned COUNT_MAX  = (1 << COUNT_W) - 1;
    localparam int          CYCLE_CAP  = 2_500_000;
    localparam int          PHASES     = 12;

    // vote tally, winner table and pixels still owed by the block
    class pixel_vote_tracker;
        int unsigned       tally[LABELS*IMAGES];
        logic [IMG_W-1:0]  winner[LABELS];
        logic [ICNT_W-1:0] image_count;
        logic [PASS_W-1:0] pass_image;
        t_out_item         pending_pixels[$];
        int                mismatches;

        function new();
            foreach (tally[i]) tally[i] = 0;
            foreach (winner[i]) winner[i] = '0;
            image_count = IMAGE_COUNT_RESET;
            pass_image  = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_IMAGE_COUNT) begin
                image_count = val[ICNT_W-1:0];
            end else if (idx == CFG_PASS_IMAGE) begin
                pass_image = val[PASS_W-1:0];
            end
        endfunction

        function void note_item(t_in_item it);
            int          n;
            int          slot;
            int unsigned best;
            t_out_item   px;
            n = (image_count > IMAGE_COUNT_MAX) ? IMAGES : int'(image_count);
            case (it.req_type)
                REQ_VOTE: begin
                    // votes for an image at or beyond the count are dropped
                    if (int'(it.vote_image) < n) begin
                        slot = int'(it.label) * IMAGES + int'(it.vote_image);
                        if (tally[slot] < COUNT_MAX) tally[slot]++;
                    end
                end
                REQ_RESOLVE: begin
                    // strict compare: ties to the lowest image, no votes to 0
                    for (int lab = 0; lab < LABELS; lab++) begin
                        best = 0;
                        winner[lab] = '0;
                        for (int img = 0; img < n; img++) begin
                            if (tally[lab*IMAGES+img] > best) begin
                                best = tally[lab*IMAGES+img];
                                winner[lab] = IMG_W'(img);
                            end
                        end
                    end
                    foreach (tally[i]) tally[i] = 0;
                end
                REQ_APPLY: begin
                    px.take_pixel = (winner[it.label] == pass_image);
                    px.out_chan0  = it.src_chan0;
                    px.out_chan1  = it.src_chan1;
                    px.out_chan2  = it.src_chan2;
                    pending_pixels.insert(pending_pixels.size(), px);
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(t_out_item got);
            t_out_item want;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: take %0d chan %h %h %h", got.take_pixel,
                             got.out_chan0, got.out_chan1, got.out_chan2);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.take_pixel !== want.take_pixel || got.out_chan0 !== want.out_chan0 ||
                got.out_chan1 !== want.out_chan1 || got.out_chan2 !== want.out_chan2) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel mismatch: expected %0d %h %h %h, got %0d %h %h %h",
                             want.take_pixel, want.out_chan0, want.out_chan1, want.out_chan2,
                             got.take_pixel, got.out_chan0, got.out_chan1, got.out_chan2);
            end
        endfunction
    endclass

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    t_out_item             o_out_item;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bit                    calm = 1'b0;
    int                    stall_left = 0;
    int                    cycles = 0;
    pixel_vote_tracker     sb = new();

    superpixel_majority_vote_compositor_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // output side stalls in random bursts while not calm
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 15);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_pixel(o_out_item);
    end

    function automatic t_in_item make_item(logic [1:0] req, int lab, int img,
                                           logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
        t_in_item it;
        it.req_type   = req;
        it.label      = LABEL_W'(lab);
        it.vote_image = IMG_W'(img);
        it.src_chan0  = c0;
        it.src_chan1  = c1;
        it.src_chan2  = c2;
        return it;
    endfunction

    function automatic int pick_label(int pool[16]);
        if ($urandom_range(0, 99) < 85) return pool[$urandom_range(0, 15)];
        return $urandom_range(0, LABELS - 1);
    endfunction

    // one item on the input channel, with an occasional gap in front
    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
    endtask

    // hold off until every pixel is back and the block is idle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_pixels.size() != 0 || !o_in_ready);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input int icount, input int pimage);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IMAGE_COUNT;
        i_cfg_data  <= CFG_DATA_W'(icount);
        @(posedge i_clk);
        sb.write_reg(CFG_IMAGE_COUNT, CFG_DATA_W'(icount));
        i_cfg_index <= CFG_PASS_IMAGE;
        i_cfg_data  <= CFG_DATA_W'(pimage);
        @(posedge i_clk);
        sb.write_reg(CFG_PASS_IMAGE, CFG_DATA_W'(pimage));
        i_cfg_we    <= 1'b0;
    endtask

    // votes on a label pool, resolve, then applies, next-pass votes and unused codes
    task automatic run_pass(input int n_votes, input int n_mixed, input bit hold_mid);
        int pool[16];
        int r;
        foreach (pool[i]) pool[i] = $urandom_range(0, LABELS - 1);
        pool[0] = 0;
        pool[1] = LABELS - 1;
        repeat (n_votes)
            send_item(make_item(REQ_VOTE, pick_label(pool), $urandom_range(0, 7),
                                8'($urandom), 8'($urandom), 8'($urandom)));
        send_item(make_item(REQ_RESOLVE, $urandom_range(0, LABELS - 1), $urandom_range(0, 7),
                            8'($urandom), 8'($urandom), 8'($urandom)));
        for (int k = 0; k < n_mixed; k++) begin
            if (hold_mid && k == n_mixed / 2) drain_results();
            r = $urandom_range(0, 99);
            if (r < 55)
                send_item(make_item(REQ_APPLY, pick_label(pool), $urandom_range(0, 7),
                                    8'($urandom), 8'($urandom), 8'($urandom)));
            else if (r < 93)
                send_item(make_item(REQ_VOTE, pick_label(pool), $urandom_range(0, 7),
                                    8'($urandom), 8'($urandom), 8'($urandom)));
            else
                send_item(make_item(REQ_UNUSED, $urandom_range(0, LABELS - 1),
                                    $urandom_range(0, 7), 8'($urandom), 8'($urandom),
                                    8'($urandom)));
        end
    endtask

    initial begin
        int pass_cfg[PHASES][2] = '{'{8, 0}, '{0, 0}, '{1, 7}, '{15, 3}, '{2, 1}, '{9, 5},
                                    '{4, 2}, '{8, 7}, '{3, 0}, '{6, 4}, '{5, 1}, '{8, 2}};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: three images, pass image 1
        set_config(3, 1);
        // resolve with no votes: every label goes to image 0
        send_item(make_item(REQ_RESOLVE, 0, 0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(REQ_APPLY, 0, 0, 8'h00, 8'h00, 8'h00));
        // tie between images 1 and 2 on label 5
        send_item(make_item(REQ_VOTE, 5, 1, 8'h01, 8'h02, 8'h03));
        send_item(make_item(REQ_VOTE, 5, 2, 8'h10, 8'h20, 8'h30));
        send_item(make_item(REQ_VOTE, 5, 2, 8'h11, 8'h22, 8'h33));
        send_item(make_item(REQ_VOTE, 5, 1, 8'h44, 8'h55, 8'h66));
        send_item(make_item(REQ_VOTE, LABELS - 1, 2, 8'hff, 8'h00, 8'hff));
        // votes at or above the image count are dropped
        send_item(make_item(REQ_VOTE, 0, 7, 8'h80, 8'h40, 8'h20));
        send_item(make_item(REQ_VOTE, 6, 3, 8'h7f, 8'hfe, 8'h01));
        // unused request code does nothing
        send_item(make_item(REQ_UNUSED, 6, 1, 8'haa, 8'h55, 8'haa));
        send_item(make_item(REQ_VOTE, 7, 1, 8'hff, 8'hff, 8'hff));
        send_item(make_item(REQ_VOTE, 8, 0, 8'h00, 8'h00, 8'h00));
        // winners from the earlier resolve still hold until the next one
        send_item(make_item(REQ_APPLY, 5, 0, 8'hff, 8'haa, 8'h55));
        send_item(make_item(REQ_RESOLVE, LABELS - 1, 7, 8'hff, 8'hff, 8'hff));
        send_item(make_item(REQ_APPLY, 5, 7, 8'hff, 8'hff, 8'hff));
        send_item(make_item(REQ_APPLY, LABELS - 1, 0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(REQ_APPLY, 0, 3, 8'h5a, 8'ha5, 8'h5a));
        send_item(make_item(REQ_APPLY, 6, 1, 8'h12, 8'h34, 8'h56));
        send_item(make_item(REQ_APPLY, 7, 2, 8'hff, 8'hff, 8'hff));
        send_item(make_item(REQ_APPLY, 8, 5, 8'h00, 8'hff, 8'h00));

        // random passes, quiet at the end
        for (int p = 0; p < PHASES; p++) begin
            set_config(pass_cfg[p][0], pass_cfg[p][1]);
            calm = (p == PHASES - 1) || ($urandom_range(0, 3) == 0);
            run_pass(40, 55, p == 4);
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/svc_pkg.sv
hw/rtl/svc_winner_unit.sv
hw/rtl/svc_vote_unit.sv
hw/rtl/superpixel_majority_vote_compositor_top.sv
tb/superpixel_majority_vote_compositor_top_test.sv
